### rtl/core/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Constants and the CORDIC arctangent table for the axis-angle rotation
// matrix block.
// ----------------------------------------------------------------------------
package aarm_pkg;

  // Width of the internal Q30 datapath words.
  localparam int unsigned QW = 34;

  localparam logic signed [QW-1:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [QW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [QW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [QW-1:0] Q30_GAIN    = 34'sd652032874;
  localparam logic signed [15:0]   Q14_ONE     = 16'sd16384;
  localparam int unsigned          ATAN_ENTRIES = 24;

  // Arctangent of 2^-i in Q30, truncated.
  function automatic logic signed [QW-1:0] atan_q30(input int unsigned i);
    logic signed [QW-1:0] v;
    begin
      case (i)
        0:  v = 34'sd843314856;
        1:  v = 34'sd497837829;
        2:  v = 34'sd263043836;
        3:  v = 34'sd133525158;
        4:  v = 34'sd67021686;
        5:  v = 34'sd33543515;
        6:  v = 34'sd16775850;
        7:  v = 34'sd8388437;
        8:  v = 34'sd4194282;
        9:  v = 34'sd2097149;
        10: v = 34'sd1048575;
        11: v = 34'sd524287;
        12: v = 34'sd262143;
        13: v = 34'sd131071;
        14: v = 34'sd65535;
        15: v = 34'sd32767;
        16: v = 34'sd16383;
        17: v = 34'sd8191;
        18: v = 34'sd4095;
        19: v = 34'sd2047;
        20: v = 34'sd1023;
        21: v = 34'sd511;
        22: v = 34'sd255;
        23: v = 34'sd127;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

### rtl/core/axis_angle_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rodrigues rotation matrix from an angle and an unnormalized axis, fully
// pipelined: square root, CORDIC, three dividers and a product tree.
// ----------------------------------------------------------------------------
// Channel   Ports                              Handshake
// input     in_angle, in_axis_x/y/z            start, busy (busy is always low)
// result    out_r00 .. out_r22, out_axis_zero  out_valid, one-cycle strobe
//
// A new word can enter in every cycle.
// The depth is set by the square root (32 stages, one root bit each) and the
// dividers (31 stages, one quotient bit each), with CORDIC running beside the
// square root stages. Valid bits ride along with the data and reset clears
// them; payload registers are not reset. The receiver cannot stall, so the
// pipeline never stops.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic               out_valid,
  output logic signed [15:0] out_r00,
  output logic signed [15:0] out_r01,
  output logic signed [15:0] out_r02,
  output logic signed [15:0] out_r10,
  output logic signed [15:0] out_r11,
  output logic signed [15:0] out_r12,
  output logic signed [15:0] out_r20,
  output logic signed [15:0] out_r21,
  output logic signed [15:0] out_r22,
  output logic               out_axis_zero
);
  import aarm_pkg::*;

  localparam int unsigned NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int unsigned SQ_STAGES = 32;
  localparam int unsigned DV_STAGES = 31;

  // Square root and CORDIC stage word.
  typedef struct packed {
    logic [31:0]          n2;
    logic [33:0]          rem;
    logic [31:0]          root;
    logic signed [QW-1:0] cx;
    logic signed [QW-1:0] cy;
    logic signed [QW-1:0] ca;
    logic                 flip;
    logic [15:0]          mx;
    logic [15:0]          my;
    logic [15:0]          mz;
    logic                 nx;
    logic                 ny;
    logic                 nz;
    logic                 zero;
  } sq_t;

  // Divider stage word.
  typedef struct packed {
    logic [31:0]          r;
    logic [32:0]          remx;
    logic [32:0]          remy;
    logic [32:0]          remz;
    logic [30:0]          qx;
    logic [30:0]          qy;
    logic [30:0]          qz;
    logic signed [QW-1:0] c;
    logic signed [QW-1:0] s;
    logic                 nx;
    logic                 ny;
    logic                 nz;
    logic                 zero;
  } dv_t;

  // Product of two Q30 values, floored back to Q30.
  function automatic logic signed [QW-1:0] mul30(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    begin
      p = (2*QW)'(a) * (2*QW)'(b);
      return p[QW+29:30];
    end
  endfunction

  // One restoring division step: returns the quotient bit and new remainder.
  function automatic logic [33:0] div_step(input logic [32:0] rem, input logic [31:0] r);
    logic [32:0] sh;
    begin
      sh = {rem[31:0], 1'b0};
      if (sh >= {1'b0, r}) begin
        return {1'b1, sh - {1'b0, r}};
      end
      return {1'b0, sh};
    end
  endfunction

  // Round a Q30 sum to Q14 and saturate to plus or minus one.
  function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
    logic signed [35:0] w;
    logic signed [19:0] q;
    begin
      w = v + 36'sd32768;
      q = w[35:16];
      if (q > 20'sd16384) begin
        return Q14_ONE;
      end
      if (q < -20'sd16384) begin
        return -Q14_ONE;
      end
      return q[15:0];
    end
  endfunction

  function automatic logic signed [35:0] ext36(input logic signed [QW-1:0] v);
    return {{2{v[QW-1]}}, v};
  endfunction

  assign busy = 1'b0;

  // Stage A: capture the input word.
  logic                 va_r;
  logic signed [15:0]   ang_r, ax_r, ay_r, az_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start & ~busy;
    end
    ang_r <= in_angle;
    ax_r  <= in_axis_x;
    ay_r  <= in_axis_y;
    az_r  <= in_axis_z;
  end

  // Stage B: squares, magnitudes and angle reduction into the CORDIC range.
  logic                 vb_r;
  logic [31:0]          sx_r, sy_r, sz_r;
  logic signed [QW-1:0] a_r;
  logic                 flip_r;
  logic [15:0]          mx_r, my_r, mz_r;
  logic                 nx_r, ny_r, nz_r, zero_r;
  logic signed [QW-1:0] a_full;
  logic signed [QW-1:0] a_nxt;
  logic                 flip_nxt;
  logic signed [31:0]   sqx, sqy, sqz;
  logic signed [16:0]   negx, negy, negz;

  always_comb begin
    a_full = {{(QW-16-17){ang_r[15]}}, ang_r, 17'd0};
    a_nxt  = a_full;
    flip_nxt = 1'b0;
    if (a_full > Q30_HALF_PI) begin
      a_nxt = a_full - Q30_PI;
      flip_nxt = 1'b1;
    end else if (a_full < -Q30_HALF_PI) begin
      a_nxt = a_full + Q30_PI;
      flip_nxt = 1'b1;
    end
    sqx  = 32'(ax_r) * 32'(ax_r);
    sqy  = 32'(ay_r) * 32'(ay_r);
    sqz  = 32'(az_r) * 32'(az_r);
    negx = -{ax_r[15], ax_r};
    negy = -{ay_r[15], ay_r};
    negz = -{az_r[15], az_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    sx_r   <= sqx;
    sy_r   <= sqy;
    sz_r   <= sqz;
    a_r    <= a_nxt;
    flip_r <= flip_nxt;
    mx_r   <= ax_r[15] ? negx[15:0] : ax_r;
    my_r   <= ay_r[15] ? negy[15:0] : ay_r;
    mz_r   <= az_r[15] ? negz[15:0] : az_r;
    nx_r   <= ax_r[15];
    ny_r   <= ay_r[15];
    nz_r   <= az_r[15];
    zero_r <= (ax_r == '0) && (ay_r == '0) && (az_r == '0);
  end

  // Stage C: squared norm, start of the square root and CORDIC pipe.
  sq_t  sq_r   [0:SQ_STAGES];
  logic sqv_r  [0:SQ_STAGES];
  sq_t  sq_nxt [0:SQ_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r[0] <= 1'b0;
    end else begin
      sqv_r[0] <= vb_r;
    end
    sq_r[0].n2   <= sx_r + sy_r + sz_r;
    sq_r[0].rem  <= '0;
    sq_r[0].root <= '0;
    sq_r[0].cx   <= Q30_GAIN;
    sq_r[0].cy   <= '0;
    sq_r[0].ca   <= a_r;
    sq_r[0].flip <= flip_r;
    sq_r[0].mx   <= mx_r;
    sq_r[0].my   <= my_r;
    sq_r[0].mz   <= mz_r;
    sq_r[0].nx   <= nx_r;
    sq_r[0].ny   <= ny_r;
    sq_r[0].nz   <= nz_r;
    sq_r[0].zero <= zero_r;
  end

  // Square root stages, one root bit each; CORDIC iterations in the first ones.
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    logic [33:0]          rem_sh;
    logic [33:0]          trial;
    logic signed [QW-1:0] dx, dy;

    always_comb begin
      sq_nxt[k] = sq_r[k];
      rem_sh = {sq_r[k].rem[31:0], sq_r[k].n2[31:30]};
      trial  = {sq_r[k].root, 2'b01};
      sq_nxt[k].n2 = {sq_r[k].n2[29:0], 2'b00};
      if (rem_sh >= trial) begin
        sq_nxt[k].rem  = rem_sh - trial;
        sq_nxt[k].root = {sq_r[k].root[30:0], 1'b1};
      end else begin
        sq_nxt[k].rem  = rem_sh;
        sq_nxt[k].root = {sq_r[k].root[30:0], 1'b0};
      end
      dx = sq_r[k].cy >>> k;
      dy = sq_r[k].cx >>> k;
      if (k < NSTEP) begin
        if (!sq_r[k].ca[QW-1]) begin
          sq_nxt[k].cx = sq_r[k].cx - dx;
          sq_nxt[k].cy = sq_r[k].cy + dy;
          sq_nxt[k].ca = sq_r[k].ca - atan_q30(k);
        end else begin
          sq_nxt[k].cx = sq_r[k].cx + dx;
          sq_nxt[k].cy = sq_r[k].cy - dy;
          sq_nxt[k].ca = sq_r[k].ca + atan_q30(k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[k+1] <= 1'b0;
      end else begin
        sqv_r[k+1] <= sqv_r[k];
      end
      sq_r[k+1] <= sq_nxt[k];
    end
  end

  // Divider entry: each dividend is the magnitude times 2^46, pre-shifted.
  dv_t  dv_r   [0:DV_STAGES];
  logic dvv_r  [0:DV_STAGES];
  dv_t  dv_nxt [0:DV_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r[0] <= 1'b0;
    end else begin
      dvv_r[0] <= sqv_r[SQ_STAGES];
    end
    dv_r[0].r    <= sq_r[SQ_STAGES].root;
    dv_r[0].remx <= {2'b00, sq_r[SQ_STAGES].mx, 15'd0};
    dv_r[0].remy <= {2'b00, sq_r[SQ_STAGES].my, 15'd0};
    dv_r[0].remz <= {2'b00, sq_r[SQ_STAGES].mz, 15'd0};
    dv_r[0].qx   <= '0;
    dv_r[0].qy   <= '0;
    dv_r[0].qz   <= '0;
    dv_r[0].c    <= sq_r[SQ_STAGES].flip ? -sq_r[SQ_STAGES].cx : sq_r[SQ_STAGES].cx;
    dv_r[0].s    <= sq_r[SQ_STAGES].flip ? -sq_r[SQ_STAGES].cy : sq_r[SQ_STAGES].cy;
    dv_r[0].nx   <= sq_r[SQ_STAGES].nx;
    dv_r[0].ny   <= sq_r[SQ_STAGES].ny;
    dv_r[0].nz   <= sq_r[SQ_STAGES].nz;
    dv_r[0].zero <= sq_r[SQ_STAGES].zero;
  end

  // Divider stages, one quotient bit of each unit component per stage.
  for (genvar k = 0; k < DV_STAGES; k++) begin : g_dv
    logic [33:0] stx, sty, stz;

    always_comb begin
      stx = div_step(dv_r[k].remx, dv_r[k].r);
      sty = div_step(dv_r[k].remy, dv_r[k].r);
      stz = div_step(dv_r[k].remz, dv_r[k].r);
      dv_nxt[k] = dv_r[k];
      dv_nxt[k].remx = stx[32:0];
      dv_nxt[k].remy = sty[32:0];
      dv_nxt[k].remz = stz[32:0];
      dv_nxt[k].qx = {dv_r[k].qx[29:0], stx[33]};
      dv_nxt[k].qy = {dv_r[k].qy[29:0], sty[33]};
      dv_nxt[k].qz = {dv_r[k].qz[29:0], stz[33]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[k+1] <= 1'b0;
      end else begin
        dvv_r[k+1] <= dvv_r[k];
      end
      dv_r[k+1] <= dv_nxt[k];
    end
  end

  // First product stage: axis outer products and axis times sine.
  logic                 m1v_r;
  logic signed [QW-1:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;
  logic signed [QW-1:0] zs1_r, ys1_r, xs1_r, c1_r, t1_r;
  logic                 zero1_r;
  logic signed [QW-1:0] ux, uy, uz, ax_mag, ay_mag, az_mag;

  always_comb begin
    ax_mag = {3'b000, dv_r[DV_STAGES].qx};
    ay_mag = {3'b000, dv_r[DV_STAGES].qy};
    az_mag = {3'b000, dv_r[DV_STAGES].qz};
    ux = dv_r[DV_STAGES].nx ? -ax_mag : ax_mag;
    uy = dv_r[DV_STAGES].ny ? -ay_mag : ay_mag;
    uz = dv_r[DV_STAGES].nz ? -az_mag : az_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1v_r <= 1'b0;
    end else begin
      m1v_r <= dvv_r[DV_STAGES];
    end
    pxx_r   <= mul30(ux, ux);
    pyy_r   <= mul30(uy, uy);
    pzz_r   <= mul30(uz, uz);
    pxy_r   <= mul30(ux, uy);
    pxz_r   <= mul30(ux, uz);
    pyz_r   <= mul30(uy, uz);
    zs1_r   <= mul30(uz, dv_r[DV_STAGES].s);
    ys1_r   <= mul30(uy, dv_r[DV_STAGES].s);
    xs1_r   <= mul30(ux, dv_r[DV_STAGES].s);
    c1_r    <= dv_r[DV_STAGES].c;
    t1_r    <= Q30_ONE - dv_r[DV_STAGES].c;
    zero1_r <= dv_r[DV_STAGES].zero;
  end

  // Second product stage: scale the outer products by one minus cosine.
  logic                 m2v_r;
  logic signed [QW-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r;
  logic signed [QW-1:0] zs2_r, ys2_r, xs2_r, c2_r;
  logic                 zero2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2v_r <= 1'b0;
    end else begin
      m2v_r <= m1v_r;
    end
    xx_r    <= mul30(pxx_r, t1_r);
    yy_r    <= mul30(pyy_r, t1_r);
    zz_r    <= mul30(pzz_r, t1_r);
    xy_r    <= mul30(pxy_r, t1_r);
    xz_r    <= mul30(pxz_r, t1_r);
    yz_r    <= mul30(pyz_r, t1_r);
    zs2_r   <= zs1_r;
    ys2_r   <= ys1_r;
    xs2_r   <= xs1_r;
    c2_r    <= c1_r;
    zero2_r <= zero1_r;
  end

  // Output stage: element sums, rounding, and the identity for a zero axis.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= m2v_r;
    end
    out_axis_zero <= zero2_r;
    if (zero2_r) begin
      out_r00 <= Q14_ONE;
      out_r01 <= '0;
      out_r02 <= '0;
      out_r10 <= '0;
      out_r11 <= Q14_ONE;
      out_r12 <= '0;
      out_r20 <= '0;
      out_r21 <= '0;
      out_r22 <= Q14_ONE;
    end else begin
      out_r00 <= to_q14(ext36(xx_r) + ext36(c2_r));
      out_r01 <= to_q14(ext36(xy_r) - ext36(zs2_r));
      out_r02 <= to_q14(ext36(xz_r) + ext36(ys2_r));
      out_r10 <= to_q14(ext36(xy_r) + ext36(zs2_r));
      out_r11 <= to_q14(ext36(yy_r) + ext36(c2_r));
      out_r12 <= to_q14(ext36(yz_r) - ext36(xs2_r));
      out_r20 <= to_q14(ext36(xz_r) - ext36(ys2_r));
      out_r21 <= to_q14(ext36(yz_r) + ext36(xs2_r));
      out_r22 <= to_q14(ext36(zz_r) + ext36(c2_r));
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for axis_angle_rotation_matrix. An in-bench fixed-point
// model predicts the nine Rodrigues matrix elements and the zero-axis flag for
// each accepted word. Every result strobe is checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aarm_pkg::*;

  localparam int unsigned STEPS      = 16;
  localparam int          PIPE_DELAY = 70;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          RAND_WORDS = 1600;

  typedef struct {
    logic signed [15:0] elem [9];
    logic               zero;
  } matrix_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] in_angle = '0;
  logic signed [15:0] in_axis_x = '0;
  logic signed [15:0] in_axis_y = '0;
  logic signed [15:0] in_axis_z = '0;
  logic               out_valid;
  logic signed [15:0] out_r00, out_r01, out_r02, out_r10, out_r11, out_r12;
  logic signed [15:0] out_r20, out_r21, out_r22;
  logic               out_axis_zero;

  matrix_t pending_matrices [$];
  int      mismatch_count = 0;
  int      idle_cycles = 0;
  logic    word_taken;

  always #6 clk = ~clk;

  axis_angle_rotation_matrix #(.CORDIC_STEPS(STEPS)) dut (.*);

  // Arithmetic shift right, rounding toward minus infinity.
  function automatic longint shr(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitpos;
    res = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= res + bitpos) begin
        v = v - (res + bitpos);
        res = (res >> 1) + bitpos;
      end else begin
        res = res >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_comp(input longint comp, input longint unsigned root);
    longint unsigned mag;
    longint q;
    mag = longint'(comp < 0 ? -comp : comp) << 46;
    q = longint'(mag / root);
    return comp < 0 ? -q : q;
  endfunction

  function automatic logic signed [15:0] round_q14(input longint v);
    longint q;
    q = (v + 32768) >>> 16;
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  // Predicted rotation matrix for one word.
  function automatic matrix_t rotation_of(input logic signed [15:0] ang,
                                          input logic signed [15:0] x,
                                          input logic signed [15:0] y,
                                          input logic signed [15:0] z);
    matrix_t m;
    longint a, ax, ay, az, cx, cy, dx, dy, c, s, t;
    longint ux, uy, uz, xx, yy, zz, xy, xz, yz;
    longint unsigned n2, root;
    bit flip;
    a = longint'(ang) * 131072;
    ax = longint'(x);
    ay = longint'(y);
    az = longint'(z);
    flip = 1'b0;
    cx = longint'(Q30_GAIN);
    cy = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      foreach (m.elem[i]) m.elem[i] = '0;
      m.elem[0] = Q14_ONE;
      m.elem[4] = Q14_ONE;
      m.elem[8] = Q14_ONE;
      m.zero = 1'b1;
      return m;
    end
    // Fold the angle into plus or minus half pi.
    if (a > longint'(Q30_HALF_PI)) begin
      a = a - longint'(Q30_PI);
      flip = 1'b1;
    end else if (a < -longint'(Q30_HALF_PI)) begin
      a = a + longint'(Q30_PI);
      flip = 1'b1;
    end
    for (int i = 0; i < int'(STEPS) && i < int'(ATAN_ENTRIES); i++) begin
      dx = shr(cy, i);
      dy = shr(cx, i);
      if (a >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        a = a - longint'(atan_q30(i));
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        a = a + longint'(atan_q30(i));
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;
    t = longint'(Q30_ONE) - c;
    // Normalize the axis.
    n2 = longint'(ax * ax) + longint'(ay * ay) + longint'(az * az);
    root = int_sqrt(n2 << 32);
    ux = unit_comp(ax, root);
    uy = unit_comp(ay, root);
    uz = unit_comp(az, root);
    xx = qmul(qmul(ux, ux), t);
    yy = qmul(qmul(uy, uy), t);
    zz = qmul(qmul(uz, uz), t);
    xy = qmul(qmul(ux, uy), t);
    xz = qmul(qmul(ux, uz), t);
    yz = qmul(qmul(uy, uz), t);
    m.elem[0] = round_q14(xx + c);
    m.elem[1] = round_q14(xy - qmul(uz, s));
    m.elem[2] = round_q14(xz + qmul(uy, s));
    m.elem[3] = round_q14(xy + qmul(uz, s));
    m.elem[4] = round_q14(yy + c);
    m.elem[5] = round_q14(yz - qmul(ux, s));
    m.elem[6] = round_q14(xz - qmul(uy, s));
    m.elem[7] = round_q14(yz + qmul(ux, s));
    m.elem[8] = round_q14(zz + c);
    m.zero = 1'b0;
    return m;
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic send_word(input logic signed [15:0] ang, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] z);
    @(negedge clk);
    start <= 1'b1;
    in_angle <= ang;
    in_axis_x <= x;
    in_axis_y <= y;
    in_axis_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_matrices.push_back(rotation_of(ang, x, y, z));
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    idle_gap(1);
    while (pending_matrices.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    return 16'($urandom_range(51472) - 25736);
  endfunction

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16) - 8);
      1: return 16'($urandom_range(2000) - 1000);
      default: return 16'($urandom());
    endcase
  endfunction

  // Angle and axis extremes, quarter turns and half turns.
  task automatic test_extremes();
    send_word(16'sd0, 16'sd1, 16'sd0, 16'sd0);
    send_word(16'sd25736, 16'sd0, 16'sd1, 16'sd0);
    send_word(-16'sd25736, 16'sd0, 16'sd0, 16'sd1);
    send_word(16'sd12868, 16'sd32767, 16'sd0, 16'sd0);
    send_word(-16'sd12868, 16'sd0, -16'sd32768, 16'sd0);
    send_word(16'sd12868, 16'sd0, 16'sd0, -16'sd32768);
    send_word(16'sd12869, 16'sd1, 16'sd1, 16'sd1);
    send_word(-16'sd12869, -16'sd32768, -16'sd32768, -16'sd32768);
    send_word(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_word(-16'sd32768, 16'sd3, -16'sd4, 16'sd5);
    send_word(16'sd8579, -16'sd1, 16'sd0, 16'sd0);
    send_word(16'sd1, 16'sd100, 16'sd200, -16'sd300);
    send_word(-16'sd1, -16'sd32768, 16'sd32767, 16'sd1);
  endtask

  // Zero axis returns the identity, for any angle.
  task automatic test_zero_axis();
    send_word(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_word(16'sd25736, 16'sd0, 16'sd0, 16'sd0);
    idle_gap(3);
    send_word(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
    send_word(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
  endtask

  // Random words in bursts, with random gaps and some unbroken stretches.
  task automatic test_random();
    int sent;
    int burst;
    logic signed [15:0] x, y, z;
    sent = 0;
    while (sent < RAND_WORDS) begin
      burst = ($urandom_range(7) == 0) ? $urandom_range(150, 60) : $urandom_range(12, 1);
      repeat (burst) begin
        x = rand_comp();
        y = rand_comp();
        z = rand_comp();
        case ($urandom_range(15))
          0: begin x = '0; y = '0; z = '0; end
          1: begin y = '0; z = '0; end
          2: begin x = '0; z = '0; end
          3: begin x = '0; y = '0; end
          default: ;
        endcase
        send_word(($urandom_range(9) == 0) ? 16'($urandom()) : rand_angle(), x, y, z);
        sent++;
      end
      if ($urandom_range(2) != 0) idle_gap($urandom_range(20, 1));
      if (sent > RAND_WORDS / 2 && sent < RAND_WORDS / 2 + 160) wait_drained();
    end
  endtask

  // Result checking against the oldest prediction.
  always @(posedge clk) begin
    matrix_t want;
    logic signed [15:0] got [9];
    string names [9];
    names = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};
    got = '{out_r00, out_r01, out_r02, out_r10, out_r11, out_r12,
            out_r20, out_r21, out_r22};
    if (rst_n && out_valid) begin
      if (pending_matrices.size() == 0) begin
        $error("result with no word outstanding");
        mismatch_count++;
      end else begin
        want = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want.elem[i]) begin
            $error("%s: expected %0d, got %0d", names[i], want.elem[i], got[i]);
            mismatch_count++;
          end
        end
        if (out_axis_zero !== want.zero) begin
          $error("axis_zero: expected %0b, got %0b", want.zero, out_axis_zero);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles where no word moves either way.
  always @(posedge clk) begin
    word_taken = start && !busy;
    if (!rst_n || word_taken || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_zero_axis();
    wait_drained();
    test_random();
    wait_drained();
    repeat (PIPE_DELAY + 10) @(posedge clk);
    if (mismatch_count == 0 && pending_matrices.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/aarm_pkg.sv
rtl/core/axis_angle_rotation_matrix.sv
tb/tb.sv
